### hdl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared constants, status codes and error mapping for the response frame
// deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam int unsigned FRAME_BYTES_MAX = 256;
  localparam int unsigned CNT_W           = $clog2(FRAME_BYTES_MAX + 1);

  localparam logic [7:0] HDR_BYTE = 8'hBB;
  localparam logic [7:0] END_BYTE = 8'h7E;
  localparam logic [7:0] TYPE_CODE_RESET = 8'h01;

  localparam logic [7:0] ERR_NO_TAG    = 8'h09;
  localparam logic [7:0] ERR_DENIED    = 8'h0A;
  localparam logic [7:0] ERR_READ_A    = 8'h05;
  localparam logic [7:0] ERR_READ_B    = 8'h06;
  localparam logic [7:0] ERR_WRITE_A   = 8'h03;
  localparam logic [7:0] ERR_WRITE_B   = 8'h04;
  localparam logic [7:0] ERR_LOCK      = 8'h0B;

  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_TIMEOUT  = 4'd1,
    ST_CHECKSUM = 4'd2,
    ST_NO_TAG   = 4'd3,
    ST_DENIED   = 4'd4,
    ST_READ     = 4'd5,
    ST_WRITE    = 4'd6,
    ST_LOCK     = 4'd7,
    ST_UNKNOWN  = 4'd8
  } status_t;

  typedef enum logic {
    IN_BYTE    = 1'b0,
    IN_TIMEOUT = 1'b1
  } in_func_t;

  typedef enum logic {
    KIND_PARAM  = 1'b0,
    KIND_STATUS = 1'b1
  } result_kind_t;

  function automatic status_t map_error(input logic [7:0] code);
    status_t st;
    case (code)
      ERR_NO_TAG:              st = ST_NO_TAG;
      ERR_DENIED:              st = ST_DENIED;
      ERR_READ_A, ERR_READ_B:  st = ST_READ;
      ERR_WRITE_A, ERR_WRITE_B: st = ST_WRITE;
      ERR_LOCK:                st = ST_LOCK;
      default:                 st = ST_UNKNOWN;
    endcase
    return st;
  endfunction

endpackage

### hdl/response_frame_deframer.sv
// ----------------------------------------------------------------------------
// response_frame_deframer
// Hunts for response frames in a received byte stream, emits parameter
// bytes as they arrive and one status item per completed frame or timeout.
// ----------------------------------------------------------------------------
// Output: the result of an accepted input item, if any, is registered in the
//   output register.
// Throughput: 1 item per cycle while the output is not stalled; the output register frees as it is taken.
// Reset: synchronous, active high; clears frame state, output valid and
//   sets response_type_code to 1.
module response_frame_deframer
  import rfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] rx_byte
  input  logic                  s_axis_tuser,  // [0] func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] data_byte, [15:8] byte_index, [23:16] frame_type,
  // [31:24] frame_command, [39:32] param_length, [43:40] status,
  // [51:44] module_error, [55:52] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,  // [0] result_kind
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);

  logic [7:0]       response_type_code;
  logic             in_frame, in_frame_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      expected_params, expected_params_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       held_type, held_type_next;
  logic [7:0]       held_command, held_command_next;
  logic [7:0]       first_param, first_param_next;
  logic [7:0]       previous_byte, previous_byte_next;

  logic             emit;
  logic             kind_next;
  logic [7:0]       data_byte_next, byte_index_next, type_out_next;
  logic [7:0]       cmd_out_next, len_out_next, mod_err_next;
  status_t          status_next;

  logic             accept;
  logic [7:0]       b;
  logic [16:0]      param_end;
  logic [16:0]      p_wide;
  logic [CNT_W-1:0] pos;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign param_end     = 17'd5 + {1'b0, expected_params};
  assign p_wide        = 17'(byte_count);
  assign pos           = byte_count - CNT_W'(5);

  always_comb begin
    in_frame_next        = in_frame;
    byte_count_next      = byte_count;
    expected_params_next = expected_params;
    running_sum_next     = running_sum;
    held_type_next       = held_type;
    held_command_next    = held_command;
    first_param_next     = first_param;
    previous_byte_next   = previous_byte;
    emit                 = 1'b0;
    kind_next            = KIND_PARAM;
    data_byte_next       = '0;
    byte_index_next      = '0;
    type_out_next        = '0;
    cmd_out_next         = '0;
    len_out_next         = '0;
    mod_err_next         = '0;
    status_next          = ST_OK;

    if (s_axis_tuser == IN_TIMEOUT) begin
      in_frame_next   = 1'b0;
      byte_count_next = '0;
      emit            = 1'b1;
      kind_next       = KIND_STATUS;
      status_next     = ST_TIMEOUT;
    end else if (!in_frame) begin
      if (b == HDR_BYTE) begin
        in_frame_next        = 1'b1;
        byte_count_next      = CNT_W'(1);
        running_sum_next     = '0;
        expected_params_next = '0;
      end
    end else if (p_wide >= 17'(FRAME_BYTES_MAX)) begin
      in_frame_next   = 1'b0;
      byte_count_next = '0;
    end else begin
      byte_count_next = byte_count + CNT_W'(1);
      if (p_wide <= 17'd4) begin
        running_sum_next   = running_sum + b;
        previous_byte_next = b;
        if (p_wide == 17'd1) held_type_next = b;
        if (p_wide == 17'd2) held_command_next = b;
        if (p_wide == 17'd4) expected_params_next = {previous_byte, b};
      end else if (p_wide < param_end) begin
        running_sum_next   = running_sum + b;
        previous_byte_next = b;
        if (pos == '0) first_param_next = b;
        emit            = 1'b1;
        data_byte_next  = b;
        byte_index_next = pos[7:0];
      end else if (p_wide == param_end) begin
        previous_byte_next = b;
      end else begin
        in_frame_next   = 1'b0;
        byte_count_next = '0;
        if (b == END_BYTE) begin
          emit          = 1'b1;
          kind_next     = KIND_STATUS;
          type_out_next = held_type;
          cmd_out_next  = held_command;
          len_out_next  = expected_params[7:0];
          if (previous_byte != running_sum) begin
            status_next = ST_CHECKSUM;
          end else if (held_type == response_type_code && expected_params == 16'd1 &&
                       first_param != 8'd0) begin
            status_next  = map_error(first_param);
            mod_err_next = first_param;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      response_type_code <= TYPE_CODE_RESET;
      in_frame           <= 1'b0;
      byte_count         <= '0;
      expected_params    <= '0;
      running_sum        <= '0;
      held_type          <= '0;
      held_command       <= '0;
      first_param        <= '0;
      previous_byte      <= '0;
      m_axis_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        response_type_code <= cfg_data;
      end
      if (accept) begin
        in_frame        <= in_frame_next;
        byte_count      <= byte_count_next;
        expected_params <= expected_params_next;
        running_sum     <= running_sum_next;
        held_type       <= held_type_next;
        held_command    <= held_command_next;
        first_param     <= first_param_next;
        previous_byte   <= previous_byte_next;
        m_axis_tvalid   <= emit;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_axis_tuser <= kind_next;
      m_axis_tdata <= {4'd0, mod_err_next, status_next, len_out_next, cmd_out_next,
                       type_out_next, byte_index_next, data_byte_next};
    end
  end

endmodule

### hdl/rfd_checker.sv
// ----------------------------------------------------------------------------
// rfd_checker
// Port-level checks for the response frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module rfd_checker
  import rfd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_timeout_status: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == IN_TIMEOUT |=>
      m_axis_tvalid && m_axis_tuser == KIND_STATUS &&
      m_axis_tdata[43:40] == ST_TIMEOUT && m_axis_tdata[39:0] == '0)
    else $error("timeout item gave no timeout status");

  a_param_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_PARAM |->
      m_axis_tdata[55:16] == '0)
    else $error("parameter item carries status fields");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_STATUS |->
      m_axis_tdata[43:40] <= ST_UNKNOWN && m_axis_tdata[15:0] == '0)
    else $error("status item malformed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind response_frame_deframer rfd_checker u_rfd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
